// ===== rtl/core/rhht_pkg.sv =====
// rhht_pkg: shared types and constants for the robin hood string hash table
// no dependencies
`default_nettype none
package rhht_pkg;
    localparam logic [31:0] MURMUR_M = 32'h5bd1e995;

    // table geometry
    localparam int NUM_BUCKETS = 256;
    localparam int BUCKET_W    = 8;
    localparam int COUNT_W     = 9;

    localparam logic [1:0] REQ_INSERT  = 2'd0;
    localparam logic [1:0] REQ_LOOKUP  = 2'd1;
    localparam logic [1:0] REQ_DELETE  = 2'd2;
    localparam logic [1:0] REQ_IGNORED = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_ZEROVAL  = 2'd3;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] key_word0;
        logic [63:0] key_word1;
        logic [63:0] key_word2;
        logic [63:0] key_word3;
        logic [4:0]  key_length;
        logic [31:0] entry_value;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] found_value;
        logic [8:0]  bucket_index;
        logic [8:0]  entry_count;
    } rsp_t;

    // classified request handed from front to back
    typedef struct packed {
        logic [1:0]   req_type;
        logic [255:0] key;
        logic [4:0]   key_length;
        logic [31:0]  entry_value;
        logic [31:0]  hash;
    } job_t;
endpackage
`default_nettype wire

// ===== rtl/core/rhht_if.sv =====
// rhht_if: valid/ready channels carrying request or response words
// depends on rhht_pkg for the payload types
`default_nettype none
interface rhht_req_if;
    logic valid;
    logic ready;
    rhht_pkg::req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rhht_rsp_if;
    logic valid;
    logic ready;
    rhht_pkg::rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/rhht_front.sv =====
// rhht_front: key masking and murmur hashing, one 32-bit multiply per cycle
// depends on rhht_pkg
`default_nettype none
module rhht_front #(
    parameter int KEY_BYTES = 32
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire rhht_pkg::req_t in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output rhht_pkg::job_t      out_data
);
    typedef enum logic [2:0] {S_IDLE, S_K1, S_K2, S_H, S_TAIL, S_F1, S_F2, S_DONE} state_t;
    state_t state_reg;
    rhht_pkg::job_t job_reg;
    logic [31:0] h_reg, k_reg;
    logic [4:0]  rem_reg;
    logic [2:0]  widx_reg;

    logic [4:0]   len_sat;
    logic [255:0] raw_key, mask;
    logic [31:0]  word_cur;
    logic [31:0]  tail_x;
    logic [31:0]  prod_h;

    // saturate length and mask bytes past it
    always_comb
    begin
        len_sat = (in_data.key_length > 5'(KEY_BYTES - 1)) ? 5'(KEY_BYTES - 1)
                                                         : in_data.key_length;
        raw_key = {in_data.key_word3, in_data.key_word2, in_data.key_word1,
                   in_data.key_word0};
        for (int b = 0; b < 32; b++)
        begin
            mask[8*b +: 8] = (5'(b) < len_sat) ? 8'hff : 8'h00;
        end
    end

    always_comb
    begin
        word_cur = job_reg.key[32*widx_reg +: 32];
        tail_x = 32'd0;
        if (rem_reg[1:0] == 2'd3)
            tail_x = {8'd0, word_cur[23:0]};
        else if (rem_reg[1:0] == 2'd2)
            tail_x = {16'd0, word_cur[15:0]};
        else if (rem_reg[1:0] == 2'd1)
            tail_x = {24'd0, word_cur[7:0]};
        prod_h = h_reg * rhht_pkg::MURMUR_M;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_DONE);
    assign out_data  = job_reg;

    // hash sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        job_reg.req_type    <= in_data.req_type;
                        job_reg.key         <= raw_key & mask;
                        job_reg.key_length  <= len_sat;
                        job_reg.entry_value <= in_data.entry_value;
                        h_reg    <= {27'd0, len_sat};
                        rem_reg  <= len_sat;
                        widx_reg <= 3'd0;
                        state_reg <= (len_sat >= 5'd4) ? S_K1 : S_TAIL;
                    end
                end
                S_K1:
                begin
                    k_reg <= word_cur * rhht_pkg::MURMUR_M;
                    state_reg <= S_K2;
                end
                S_K2:
                begin
                    k_reg <= (k_reg ^ (k_reg >> 24)) * rhht_pkg::MURMUR_M;
                    state_reg <= S_H;
                end
                S_H:
                begin
                    h_reg    <= prod_h ^ k_reg;
                    rem_reg  <= rem_reg - 5'd4;
                    widx_reg <= widx_reg + 3'd1;
                    state_reg <= (rem_reg >= 5'd8) ? S_K1 : S_TAIL;
                end
                S_TAIL:
                begin
                    if (rem_reg[1:0] != 2'd0)
                        h_reg <= (h_reg ^ tail_x) * rhht_pkg::MURMUR_M;
                    state_reg <= S_F1;
                end
                S_F1:
                begin
                    h_reg <= (h_reg ^ (h_reg >> 13)) * rhht_pkg::MURMUR_M;
                    state_reg <= S_F2;
                end
                S_F2:
                begin
                    job_reg.hash <= h_reg ^ (h_reg >> 15);
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_ready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/rhht_queue.sv =====
// rhht_queue: two-entry queue between hashing front and table back
// depends on rhht_pkg
`default_nettype none
module rhht_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire rhht_pkg::job_t in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output rhht_pkg::job_t      out_data
);
    rhht_pkg::job_t mem_reg [2];
    logic rd_reg, wr_reg;
    logic [1:0] cnt_reg;
    logic push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = mem_reg[rd_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= in_data;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wr_reg <= ~wr_reg;
            if (pop)
                rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/rhht_back.sv =====
// rhht_back: table memories and insert/lookup/delete walks
// depends on rhht_pkg
`default_nettype none
module rhht_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire rhht_pkg::job_t in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output rhht_pkg::rsp_t      out_data
);
    localparam int NUM_BUCKETS = rhht_pkg::NUM_BUCKETS;
    localparam int IW = rhht_pkg::BUCKET_W;
    localparam int CW = rhht_pkg::COUNT_W;

    typedef enum logic [3:0] {
        S_IDLE, S_MOD, S_MOD2, S_FIND_RD, S_FIND_CK, S_INS_RD, S_INS_CK,
        S_DEL_RD, S_DEL_CK, S_CLR, S_RESP
    } state_t;

    // entry memories; valid flags cover the key, length, value and distance stores
    logic [255:0]    key_mem  [NUM_BUCKETS];
    logic [4:0]      len_mem  [NUM_BUCKETS];
    logic [31:0]     val_mem  [NUM_BUCKETS];
    logic [IW-1:0]   dist_mem [NUM_BUCKETS];
    logic [NUM_BUCKETS-1:0] vld_reg;
    logic [NUM_BUCKETS-1:0] vld_next;

    state_t state_reg;
    rhht_pkg::job_t job_reg;
    logic [31:0]   hq_reg;
    logic [IW-1:0] ideal_reg, idx_reg;
    logic [IW-1:0] edist_reg;
    logic [255:0]  ckey_reg;
    logic [4:0]    clen_reg;
    logic [31:0]   cval_reg;
    logic          first_set_reg;
    logic [CW-1:0] count_reg, steps_reg;
    rhht_pkg::rsp_t rsp_reg;

    // registered slot read
    logic [255:0]  rd_key_reg;
    logic [4:0]    rd_len_reg;
    logic [31:0]   rd_val_reg;
    logic [IW-1:0] rd_dist_reg;
    logic          rd_vld_reg;

    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [255:0]  wr_key;
    logic [4:0]    wr_len;
    logic [31:0]   wr_val;
    logic [IW-1:0] wr_dist;
    logic          clr_en;
    logic [IW-1:0] clr_addr;

    localparam logic [IW:0] NB = (IW+1)'(NUM_BUCKETS);

    function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] a);
        logic [IW:0] s;
        s = {1'b0, a} + (IW+1)'(1);
        wrap_inc = (s >= NB) ? IW'(s - NB) : IW'(s);
    endfunction

    function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] a, input logic [IW-1:0] b);
        logic [IW:0] s;
        s = {1'b0, a} + {1'b0, b};
        wrap_add = (s >= NB) ? IW'(s - NB) : IW'(s);
    endfunction

    function automatic logic [IW-1:0] wrap_sub(input logic [IW-1:0] a, input logic [IW-1:0] b);
        wrap_sub = (a >= b) ? (a - b) : IW'(NB + {1'b0, a} - {1'b0, b});
    endfunction

    logic occ;
    logic key_hit;
    logic find_stop;
    logic [IW-1:0] sideal;
    logic takes;

    always_comb
    begin
        occ = rd_vld_reg && (rd_val_reg != 32'd0);
        key_hit = occ && (rd_len_reg == job_reg.key_length) &&
                  (rd_key_reg == job_reg.key);
        find_stop = !occ || (steps_reg != '0 && rd_dist_reg == '0) ||
                    steps_reg >= CW'(NUM_BUCKETS);
        sideal = wrap_sub(idx_reg, rd_dist_reg);
        takes = !occ || (edist_reg > rd_dist_reg) ||
                ((edist_reg == rd_dist_reg) && (ideal_reg < sideal));
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_RESP);
    assign out_data  = rsp_reg;

    // memory read, write and clear ports
    always_ff @(posedge clk)
    begin
        rd_key_reg  <= key_mem[rd_addr];
        rd_len_reg  <= len_mem[rd_addr];
        rd_val_reg  <= val_mem[rd_addr];
        rd_dist_reg <= dist_mem[rd_addr];
        if (wr_en)
        begin
            key_mem[wr_addr]  <= wr_key;
            len_mem[wr_addr]  <= wr_len;
            val_mem[wr_addr]  <= wr_val;
            dist_mem[wr_addr] <= wr_dist;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_vld_reg <= 1'b0;
        else
            rd_vld_reg <= vld_reg[rd_addr] && !(wr_en && wr_addr == rd_addr && wr_val == 32'd0)
                          && !(clr_en && clr_addr == rd_addr);
    end

    // port drive per state
    always_comb
    begin
        rd_addr  = idx_reg;
        wr_en    = 1'b0;
        wr_addr  = idx_reg;
        wr_key   = ckey_reg;
        wr_len   = clen_reg;
        wr_val   = cval_reg;
        wr_dist  = edist_reg;
        clr_en   = 1'b0;
        clr_addr = idx_reg;
        case (state_reg)
            S_FIND_CK:
            begin
                // free the slot of a key found for delete
                clr_en = !find_stop && key_hit &&
                         (job_reg.req_type == rhht_pkg::REQ_DELETE);
            end
            S_INS_CK:
            begin
                wr_en = takes;
            end
            S_DEL_CK:
            begin
                // move next entry back one slot
                wr_en   = occ && (rd_dist_reg != '0);
                wr_addr = wrap_sub(idx_reg, IW'(1));
                wr_key  = rd_key_reg;
                wr_len  = rd_len_reg;
                wr_val  = rd_val_reg;
                wr_dist = rd_dist_reg - IW'(1);
                clr_en  = 1'b1;
                clr_addr = (occ && (rd_dist_reg != '0)) ? idx_reg : wrap_sub(idx_reg, IW'(1));
            end
            default: ;
        endcase
    end

    // valid flags follow the write and clear ports
    always_comb
    begin
        vld_next = vld_reg;
        if (wr_en)
            vld_next[wr_addr] = 1'b1;
        if (clr_en)
            vld_next[clr_addr] = 1'b0;
    end

    // table sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            vld_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        job_reg   <= in_data;
                        hq_reg    <= in_data.hash;
                        ckey_reg  <= in_data.key;
                        clen_reg  <= in_data.key_length;
                        cval_reg  <= in_data.entry_value;
                        rsp_reg.status       <= rhht_pkg::ST_NOTFOUND;
                        rsp_reg.found_value  <= 32'd0;
                        rsp_reg.bucket_index <= 9'(NUM_BUCKETS);
                        state_reg <= S_MOD;
                    end
                end
                S_MOD:
                begin
                    // power-of-two bucket count reduces by mask
                    ideal_reg <= hq_reg[IW-1:0];
                    idx_reg   <= hq_reg[IW-1:0];
                    state_reg <= S_MOD2;
                end
                S_MOD2:
                begin
                    edist_reg     <= '0;
                    first_set_reg <= 1'b0;
                    steps_reg     <= '0;
                    case (job_reg.req_type)
                        rhht_pkg::REQ_INSERT:
                        begin
                            if (count_reg >= CW'(NUM_BUCKETS))
                            begin
                                rsp_reg.status <= rhht_pkg::ST_FULL;
                                rsp_reg.entry_count <= count_reg;
                                state_reg <= S_RESP;
                            end
                            else if (job_reg.entry_value == 32'd0)
                            begin
                                rsp_reg.status <= rhht_pkg::ST_ZEROVAL;
                                rsp_reg.entry_count <= count_reg;
                                state_reg <= S_RESP;
                            end
                            else
                                state_reg <= S_INS_RD;
                        end
                        rhht_pkg::REQ_LOOKUP, rhht_pkg::REQ_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                rsp_reg.entry_count <= count_reg;
                                state_reg <= S_RESP;
                            end
                            else
                                state_reg <= S_FIND_RD;
                        end
                        default:
                        begin
                            rsp_reg.entry_count <= count_reg;
                            state_reg <= S_RESP;
                        end
                    endcase
                end
                S_FIND_RD: state_reg <= S_FIND_CK;
                S_FIND_CK:
                begin
                    if (find_stop)
                    begin
                        rsp_reg.entry_count <= count_reg;
                        state_reg <= S_RESP;
                    end
                    else if (key_hit)
                    begin
                        rsp_reg.status <= rhht_pkg::ST_OK;
                        rsp_reg.bucket_index <= 9'(idx_reg);
                        if (job_reg.req_type == rhht_pkg::REQ_LOOKUP)
                        begin
                            rsp_reg.found_value <= rd_val_reg;
                            rsp_reg.entry_count <= count_reg;
                            state_reg <= S_RESP;
                        end
                        else
                        begin
                            // found slot is cleared, then walk forward shifting back
                            count_reg <= count_reg - CW'(1);
                            idx_reg <= wrap_inc(idx_reg);
                            steps_reg <= '0;
                            state_reg <= S_DEL_RD;
                        end
                    end
                    else
                    begin
                        idx_reg   <= wrap_inc(idx_reg);
                        steps_reg <= steps_reg + CW'(1);
                        state_reg <= S_FIND_RD;
                    end
                end
                S_DEL_RD: state_reg <= S_DEL_CK;
                S_DEL_CK:
                begin
                    if (occ && (rd_dist_reg != '0) && steps_reg < CW'(NUM_BUCKETS))
                    begin
                        idx_reg   <= wrap_inc(idx_reg);
                        steps_reg <= steps_reg + CW'(1);
                        state_reg <= S_DEL_RD;
                    end
                    else
                    begin
                        rsp_reg.entry_count <= count_reg;
                        state_reg <= S_RESP;
                    end
                end
                S_INS_RD: state_reg <= S_INS_CK;
                S_INS_CK:
                begin
                    if (takes)
                    begin
                        if (!first_set_reg)
                        begin
                            first_set_reg <= 1'b1;
                            rsp_reg.bucket_index <= 9'(idx_reg);
                        end
                        if (!occ)
                        begin
                            rsp_reg.status <= rhht_pkg::ST_OK;
                            count_reg <= count_reg + CW'(1);
                            rsp_reg.entry_count <= count_reg + CW'(1);
                            state_reg <= S_RESP;
                        end
                        else
                        begin
                            // bumped entry restarts its probe at its home bucket
                            ckey_reg  <= rd_key_reg;
                            clen_reg  <= rd_len_reg;
                            cval_reg  <= rd_val_reg;
                            ideal_reg <= sideal;
                            edist_reg <= '0;
                            idx_reg   <= sideal;
                            state_reg <= S_INS_RD;
                        end
                    end
                    else
                    begin
                        edist_reg <= edist_reg + IW'(1);
                        idx_reg   <= wrap_add(ideal_reg, edist_reg + IW'(1));
                        state_reg <= S_INS_RD;
                    end
                end
                S_RESP:
                begin
                    if (out_ready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/robin_hood_string_hash_table.sv =====
// robin_hood_string_hash_table: top level, front hasher, queue and table back end
// depends on rhht_pkg, rhht_if, rhht_front, rhht_queue, rhht_back
`default_nettype none
// Each request word (insert, lookup, delete or ignored) yields one response
// word. The front hashes with one 32-bit multiply per cycle while busy: it
// accepts a word, runs key-mix and combine states per whole 4-byte key word,
// then tail, final mix and handoff. The back end walks the table through a
// registered read port, a read and a check state per probed or shifted slot
// after setup, then a response state; an entry bumped by an insert restarts
// its probe at its own home bucket. A two-word queue between the parts lets
// the next key hash while the table works on the previous one. No clearing
// pass after reset: per-bucket valid flags mark the empty buckets.
module robin_hood_string_hash_table #(
    parameter int KEY_BYTES = 32
) (
    input wire logic     clk,
    input wire logic     rst_n,
    rhht_req_if.sink     req,
    rhht_rsp_if.source   rsp
);
    logic f_valid, f_ready, b_valid, b_ready;
    rhht_pkg::job_t f_job, b_job;

    rhht_front #(.KEY_BYTES(KEY_BYTES)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(req.valid), .in_ready(req.ready), .in_data(req.data),
        .out_valid(f_valid), .out_ready(f_ready), .out_data(f_job)
    );

    rhht_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .in_valid(f_valid), .in_ready(f_ready), .in_data(f_job),
        .out_valid(b_valid), .out_ready(b_ready), .out_data(b_job)
    );

    rhht_back u_back (
        .clk(clk), .rst_n(rst_n),
        .in_valid(b_valid), .in_ready(b_ready), .in_data(b_job),
        .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.data)
    );
endmodule
`default_nettype wire

// ===== rtl/core/rhht_checker.sv =====
// rhht_checker: port-level assertions for the hash table
// depends on rhht_pkg, bound to robin_hood_string_hash_table
`default_nettype none
module rhht_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic rsp_valid,
    input wire logic rsp_ready,
    input wire rhht_pkg::rsp_t rsp_data
);
    // stalled response word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("response changed while stalled");

    // found value is zero on every failed request
    a_found: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.status != rhht_pkg::ST_OK |-> rsp_data.found_value == 32'd0)
        else $error("found value on failed request");

    // not-found responses report no bucket
    a_bidx: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.status == rhht_pkg::ST_NOTFOUND |->
            rsp_data.bucket_index == 9'(rhht_pkg::NUM_BUCKETS))
        else $error("bucket index on miss");
endmodule

bind robin_hood_string_hash_table rhht_checker u_chk (
    .clk(clk), .rst_n(rst_n), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
    .rsp_data(rsp.data)
);
`default_nettype wire

// ===== dv/tb.sv =====
// tb: self-checking testbench for robin_hood_string_hash_table
// depends on rhht_pkg, rhht_if and the table rtl; holds its own table predictor
`timescale 1ns / 1ps
module tb;
    localparam int NB = rhht_pkg::NUM_BUCKETS;
    localparam int MAXLEN = 31;
    localparam int STALL_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;

    // one table slot as the predictor keeps it
    typedef struct {
        logic [255:0] key;
        int           len;
        logic [31:0]  value;
        int           distance;
    } slot_t;

    class hash_table_scoreboard;
        slot_t                table_q[NB];
        int                   count;
        rhht_pkg::rsp_t       pending_rsp[$];
        int                   errors;

        function new();
            slot_t z;
            z.key = '0;
            z.len = 0;
            z.value = '0;
            z.distance = 0;
            foreach (table_q[i]) table_q[i] = z;
            count = 0;
            errors = 0;
        endfunction

        // seed-0 murmur2 over the valid bytes, reduced to a bucket
        function int bucket_of(logic [255:0] key, int len);
            bit [31:0] h, k;
            int p, rem;
            h = len;
            p = 0;
            rem = len;
            while (rem >= 4) begin
                k = key[8*p +: 32];
                k = k * rhht_pkg::MURMUR_M;
                k = k ^ (k >> 24);
                k = k * rhht_pkg::MURMUR_M;
                h = h * rhht_pkg::MURMUR_M;
                h = h ^ k;
                p += 4;
                rem -= 4;
            end
            if (rem == 3) h = h ^ (32'(key[8*(p+2) +: 8]) << 16);
            if (rem >= 2) h = h ^ (32'(key[8*(p+1) +: 8]) << 8);
            if (rem >= 1) begin
                h = h ^ 32'(key[8*p +: 8]);
                h = h * rhht_pkg::MURMUR_M;
            end
            h = h ^ (h >> 13);
            h = h * rhht_pkg::MURMUR_M;
            h = h ^ (h >> 15);
            return int'(h % NB);
        endfunction

        function bit holds(int i, slot_t e);
            return table_q[i].value != 0 && table_q[i].len == e.len && table_q[i].key == e.key;
        endfunction

        function int locate(slot_t e);
            int t;
            if (count == 0) return NB;
            t = bucket_of(e.key, e.len);
            if (table_q[t].value == 0) return NB;
            for (int i = 0; i < NB; i++) begin
                if (holds(t, e)) return t;
                t = (t + 1) % NB;
                if (table_q[t].value == 0 || table_q[t].distance == 0) break;
            end
            return NB;
        endfunction

        // walk from home until slot is empty or carried entry is poorer than resident, or as poor with lower home
        function int probe_slot(int home, inout slot_t e);
            int idx, sd, s_home;
            idx = home;
            for (int it = 0; it < NB; it++) begin
                sd = table_q[idx].distance;
                s_home = (idx + NB - (sd % NB)) % NB;
                if (table_q[idx].value == 0 || e.distance > sd ||
                    (e.distance == sd && home < s_home))
                    break;
                e.distance++;
                idx = (home + e.distance) % NB;
            end
            return idx;
        endfunction

        function int place(slot_t e);
            int home, first, at;
            slot_t old;
            home = bucket_of(e.key, e.len);
            first = NB;
            e.distance = 0;
            for (int it = 0; it < NB && e.value != 0; it++) begin
                at = probe_slot(home, e);
                old = table_q[at];
                table_q[at] = e;
                if (it == 0) first = at;
                e = old;
                e.distance = 0;
                home = (at + NB - (old.distance % NB)) % NB;
            end
            count++;
            return first;
        endfunction

        function void clear(int i);
            table_q[i].key = '0;
            table_q[i].len = 0;
            table_q[i].value = '0;
            table_q[i].distance = 0;
        endfunction

        // pull the displaced run behind a freed slot back by one
        function void close_gap(int idx);
            int nx;
            for (int i = 0; i < NB; i++) begin
                nx = (idx + 1) % NB;
                if (table_q[nx].value == 0 || table_q[nx].distance == 0) return;
                table_q[idx] = table_q[nx];
                table_q[idx].distance--;
                clear(nx);
                idx = nx;
            end
        endfunction

        function void note_request(rhht_pkg::req_t r);
            slot_t e;
            rhht_pkg::rsp_t o;
            int at;
            logic [255:0] raw;
            e.len = (r.key_length > MAXLEN) ? MAXLEN : int'(r.key_length);
            raw = {r.key_word3, r.key_word2, r.key_word1, r.key_word0};
            for (int b = 0; b < 32; b++)
                e.key[8*b +: 8] = (b < e.len) ? raw[8*b +: 8] : 8'h00;
            e.value = r.entry_value;
            e.distance = 0;
            o.status = rhht_pkg::ST_NOTFOUND;
            o.found_value = '0;
            o.bucket_index = 9'(NB);
            if (r.req_type == rhht_pkg::REQ_INSERT) begin
                if (count >= NB) o.status = rhht_pkg::ST_FULL;
                else if (e.value == 0) o.status = rhht_pkg::ST_ZEROVAL;
                else begin
                    o.bucket_index = 9'(place(e));
                    o.status = rhht_pkg::ST_OK;
                end
            end else if (r.req_type == rhht_pkg::REQ_LOOKUP) begin
                at = locate(e);
                if (at < NB) begin
                    o.status = rhht_pkg::ST_OK;
                    o.found_value = table_q[at].value;
                    o.bucket_index = 9'(at);
                end
            end else if (r.req_type == rhht_pkg::REQ_DELETE) begin
                at = locate(e);
                if (at < NB) begin
                    o.status = rhht_pkg::ST_OK;
                    o.bucket_index = 9'(at);
                    clear(at);
                    if (count > 0) count--;
                    close_gap(at);
                end
            end
            o.entry_count = 9'(count);
            pending_rsp.push_back(o);
        endfunction

        function void check_response(rhht_pkg::rsp_t got);
            rhht_pkg::rsp_t want;
            if (pending_rsp.size() == 0) begin
                $display("%0t: unexpected response, actual %h", $realtime, got);
                errors++;
                return;
            end
            want = pending_rsp.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $realtime, want.status, got.status);
                errors++;
            end
            if (got.found_value !== want.found_value) begin
                $display("%0t: found_value expected %h actual %h", $realtime,
                         want.found_value, got.found_value);
                errors++;
            end
            if (got.bucket_index !== want.bucket_index) begin
                $display("%0t: bucket_index expected %0d actual %0d", $realtime,
                         want.bucket_index, got.bucket_index);
                errors++;
            end
            if (got.entry_count !== want.entry_count) begin
                $display("%0t: entry_count expected %0d actual %0d", $realtime,
                         want.entry_count, got.entry_count);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    rhht_req_if req_ch();
    rhht_rsp_if rsp_ch();

    robin_hood_string_hash_table i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #5 clk = ~clk;

    hash_table_scoreboard sb = new();
    int   tx_idle_pct = 0;
    int   rx_stall_pct = 0;
    bit   hold_req = 1'b0;
    int   quiet_cycles = 0;
    rhht_pkg::req_t key_pool[$];

    initial
    begin
        req_ch.valid <= 1'b0;
        req_ch.data <= '0;
        rsp_ch.ready <= 1'b0;
    end

    // response side: ready with random stalls, long hold-off on request
    initial
    begin
        bit   fire;
        rhht_pkg::rsp_t word;
        int   hold_cnt;
        fire = 1'b0;
        hold_cnt = 0;
        forever
        begin
            @(posedge clk);
            if (fire) sb.check_response(word);
            if (hold_req && hold_cnt == 0) hold_cnt = HOLD_CYCLES;
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                if (hold_cnt == 0) hold_req = 1'b0;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= rst_n && ($urandom_range(99) >= rx_stall_pct);
            @(negedge clk);
            fire = rsp_ch.valid && rsp_ch.ready;
            word = rsp_ch.data;
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(negedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
        else if (rst_n)
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("robin_hood_string_hash_table verification failed");
            $finish;
        end
    end

    // called at a rising edge; returns at the edge where the word is taken
    task automatic send(rhht_pkg::req_t r, bit gaps);
        while (gaps && $urandom_range(99) < tx_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data <= r;
        do @(negedge clk); while (!req_ch.ready);
        @(posedge clk);
        sb.note_request(r);
    endtask

    task automatic go_idle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic rhht_pkg::req_t make_req(logic [1:0] op, int len, logic [31:0] val);
        rhht_pkg::req_t r;
        r.req_type = op;
        r.key_word0 = {$urandom, $urandom};
        r.key_word1 = {$urandom, $urandom};
        r.key_word2 = {$urandom, $urandom};
        r.key_word3 = {$urandom, $urandom};
        r.key_length = 5'(len);
        r.entry_value = val;
        return r;
    endfunction

    // same key with fresh garbage past its length
    function automatic rhht_pkg::req_t reuse_key(rhht_pkg::req_t k, logic [1:0] op);
        rhht_pkg::req_t r;
        logic [255:0] raw, noise;
        r = make_req(op, int'(k.key_length), {$urandom} | 32'h1);
        raw = {k.key_word3, k.key_word2, k.key_word1, k.key_word0};
        noise = {r.key_word3, r.key_word2, r.key_word1, r.key_word0};
        for (int b = 0; b < int'(k.key_length); b++) noise[8*b +: 8] = raw[8*b +: 8];
        {r.key_word3, r.key_word2, r.key_word1, r.key_word0} = noise;
        return r;
    endfunction

    function automatic int pick_len();
        int c;
        c = $urandom_range(99);
        if (c < 70) return $urandom_range(8);
        if (c < 90) return $urandom_range(16);
        return $urandom_range(MAXLEN);
    endfunction

    task automatic random_item(int ins_pct, bit gaps);
        rhht_pkg::req_t r;
        int   c, j;
        c = $urandom_range(99);
        if (c < ins_pct)
        begin
            r = make_req(rhht_pkg::REQ_INSERT, pick_len(),
                         ($urandom_range(99) < 3) ? 32'h0 : $urandom);
            if (key_pool.size() > 0 && $urandom_range(99) < 5)
                r = reuse_key(key_pool[$urandom_range(key_pool.size() - 1)],
                              rhht_pkg::REQ_INSERT);
            if (r.entry_value != 0) key_pool.push_back(r);
        end
        else if (c < 97)
        begin
            r = make_req((c < ins_pct + (97 - ins_pct) / 2) ? rhht_pkg::REQ_LOOKUP
                                                            : rhht_pkg::REQ_DELETE,
                         pick_len(), $urandom);
            if (key_pool.size() > 0 && $urandom_range(99) < 80)
            begin
                j = $urandom_range(key_pool.size() - 1);
                r = reuse_key(key_pool[j], r.req_type);
                if (r.req_type == rhht_pkg::REQ_DELETE) key_pool.delete(j);
            end
        end
        else
            r = make_req(rhht_pkg::REQ_IGNORED, pick_len(), $urandom);
        send(r, gaps);
    endtask

    initial
    begin
        rhht_pkg::req_t a, b;
        int   ins_mix[4];
        int   tx_mix[4];
        int   rx_mix[4];
        ins_mix = '{45, 75, 45, 25};
        tx_mix = '{0, 53, 0, 25};
        rx_mix = '{0, 0, 53, 25};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes of key and value, every request type, corner cases
        a = make_req(rhht_pkg::REQ_INSERT, 0, 32'h1);
        b = make_req(rhht_pkg::REQ_INSERT, MAXLEN, 32'hffff_ffff);
        b.key_word0 = '1; b.key_word1 = '1; b.key_word2 = '1; b.key_word3 = '1;
        send(make_req(rhht_pkg::REQ_LOOKUP, 3, 32'h5), 1'b0);
        send(make_req(rhht_pkg::REQ_DELETE, 3, 32'h5), 1'b0);
        send(a, 1'b0);
        send(b, 1'b0);
        send(reuse_key(a, rhht_pkg::REQ_LOOKUP), 1'b0);
        send(reuse_key(b, rhht_pkg::REQ_LOOKUP), 1'b0);
        send(make_req(rhht_pkg::REQ_INSERT, 6, 32'h0), 1'b0);
        send(make_req(rhht_pkg::REQ_IGNORED, MAXLEN, 32'h7), 1'b0);
        send(reuse_key(b, rhht_pkg::REQ_INSERT), 1'b0);
        send(reuse_key(b, rhht_pkg::REQ_DELETE), 1'b0);
        send(reuse_key(b, rhht_pkg::REQ_LOOKUP), 1'b0);
        send(reuse_key(b, rhht_pkg::REQ_DELETE), 1'b0);
        send(reuse_key(b, rhht_pkg::REQ_DELETE), 1'b0);
        for (int len = 1; len <= 9; len++)
        begin
            a = make_req(rhht_pkg::REQ_INSERT, len, $urandom | 32'h1);
            send(a, 1'b0);
            send(reuse_key(a, rhht_pkg::REQ_LOOKUP), 1'b0);
        end
        go_idle();
        wait (sb.pending_rsp.size() == 0);

        // random phases with different idle mixes
        for (int ph = 0; ph < 4; ph++)
        begin
            tx_idle_pct = tx_mix[ph];
            rx_stall_pct = rx_mix[ph];
            if (ph == 1)
            begin
                hold_req = 1'b1;
                repeat (40) random_item(50, 1'b0);
            end
            repeat (300) random_item(ins_mix[ph], 1'b1);
            repeat ($urandom_range(30)) random_item(ins_mix[ph], 1'b0);
        end
        go_idle();

        wait (sb.pending_rsp.size() == 0);
        repeat (600) @(posedge clk);
        if (sb.errors == 0 && sb.pending_rsp.size() == 0)
            $display("robin_hood_string_hash_table verification clean");
        else
            $display("robin_hood_string_hash_table verification failed");
        $finish;
    end
endmodule

// ===== robin_hood_string_hash_table.f =====
rtl/core/rhht_pkg.sv
rtl/core/rhht_if.sv
rtl/core/rhht_front.sv
rtl/core/rhht_queue.sv
rtl/core/rhht_back.sv
rtl/core/robin_hood_string_hash_table.sv
rtl/core/rhht_checker.sv
dv/tb.sv
